[sv/ssbn_pkg.sv]
// shared widths, codes and state type of the slice bounds normalizer
package ssbn_pkg;

    localparam int MAX_RANK_DEF = 8;

    localparam int RANK_W = 4;                  // tensor_rank register
    localparam int IDX_W  = 3;                  // dim_index and axis_out
    localparam int AXIS_W = 4;                  // signed axis_raw
    localparam int RAW_W  = 64;                 // start/end/step raw fields
    localparam int DIM_W  = 31;                 // dimension size and unsigned results
    localparam int OUT_W  = 32;                 // signed end_out and step_out
    localparam int CNT_W  = $clog2(RAW_W);      // bit counter for the serial passes

    localparam logic [DIM_W-1:0] S32_MAX = '1;  // largest 32-bit signed value

    typedef enum logic [0:0] {
        REQ_LOAD = 1'b0,
        REQ_AXIS = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_DUP   = 2'd2,
        STAT_ZSTEP = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_ASM,
        S_DIFF,
        S_DIV,
        S_FIN,
        S_EMIT
    } t_state;

endpackage

[sv/strided_slice_bounds_normalizer.sv]
// slice bounds normalizer: shape table, serial clamp pass and serial ceiling divider
// Takes one item at a time. A load item writes one dimension size into the shape
// table; an axis item wraps and checks the axis against tensor_rank and the seen
// mask, then clamps step, start and end against the dimension size and gives the
// number of selected elements. Load items and rejected axis items (out of range,
// duplicate, zero step) go from acceptance through the emit step to the output
// register. A normal axis item runs a bit-serial pass over the 64-bit start, end
// and step fields, one bit per cycle, then a restoring divider that retires one
// quotient bit per cycle; it steps through setup, scan, assembly, difference,
// divide, final and emit, skipping difference, divide and final when the dimension
// size is zero and divide and final when the selected length is zero or negative.
// Apart from the emit step's stall wait, the serial pass and the divider are the
// only loops. The next item is accepted in the cycle after the result is loaded,
// even while the receiver stalls it; a result that is still stalled holds the
// following one in the last step. Shape table entries read by an axis item must
// have been loaded first; tensor_rank is to be written only while the block is
// idle, which the block itself does not enforce.
module strided_slice_bounds_normalizer #(
    parameter int MAX_RANK = ssbn_pkg::MAX_RANK_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [ssbn_pkg::RANK_W-1:0]         i_cfg_wdata,
    // input item channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_req_type,
    input  logic [ssbn_pkg::IDX_W-1:0]          i_dim_index,
    input  logic [ssbn_pkg::DIM_W-1:0]          i_dim_size,
    input  logic                                i_first_of_slice,
    input  logic signed [ssbn_pkg::AXIS_W-1:0]  i_axis_raw,
    input  logic signed [ssbn_pkg::RAW_W-1:0]   i_start_raw,
    input  logic signed [ssbn_pkg::RAW_W-1:0]   i_end_raw,
    input  logic signed [ssbn_pkg::RAW_W-1:0]   i_step_raw,
    // result item channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_status,
    output logic [ssbn_pkg::IDX_W-1:0]          o_axis_out,
    output logic [ssbn_pkg::DIM_W-1:0]          o_start_out,
    output logic signed [ssbn_pkg::OUT_W-1:0]   o_end_out,
    output logic signed [ssbn_pkg::OUT_W-1:0]   o_step_out,
    output logic [ssbn_pkg::DIM_W-1:0]          o_out_length
);

    // table index width; the rank is compared in one bit more than the register
    localparam int AW  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int RKW = ssbn_pkg::RANK_W + 1;
    localparam int RW  = ssbn_pkg::RAW_W;
    localparam int DW  = ssbn_pkg::DIM_W;
    localparam int OW  = ssbn_pkg::OUT_W;
    localparam int CW  = ssbn_pkg::CNT_W;

    localparam logic [CW-1:0] SCAN_LAST = CW'(RW - 1);   // last bit of the serial pass
    localparam logic [CW-1:0] DIV_LAST  = CW'(DW - 1);   // last quotient bit
    localparam logic [CW-1:0] SENT_LOW  = CW'(DW);       // ones below this bit: int32 max

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    ssbn_pkg::t_state  r_state, n_state;
    logic [ssbn_pkg::RANK_W-1:0] r_rank;
    logic [DW-1:0]     r_table [MAX_RANK];
    logic [MAX_RANK-1:0] r_seen, n_seen;

    // serial pass operands and running flags
    logic [DW-1:0]     r_dim;          // size of the selected dimension
    logic [DW-1:0]     r_d_sr;         // dimension size, shifted out lsb first
    logic [DW-1:0]     r_b_sr;         // step bound, shifted out lsb first
    logic [RW-1:0]     r_step_sr;      // rotates, back in place after the pass
    logic [RW-1:0]     r_start_sr;     // becomes start wrapped by the dimension
    logic [RW-1:0]     r_end_sr;       // becomes end wrapped by the dimension
    logic              r_step_neg, r_start_neg, r_end_neg;
    logic              r_st_gt;        // step above +bound
    logic              r_st_lt;        // step below -bound
    logic              r_nb_c;         // serial negation of the bound: a one seen
    logic              r_sc, r_ec;     // serial adder carries
    logic              r_x_ge;         // wrapped start above its upper limit
    logic              r_y_gt;         // wrapped end above the dimension size
    logic              r_y_ones;       // wrapped end is all ones
    logic              r_e32, r_e64;   // end equals one of the int max markers
    logic [CW-1:0]     r_cnt;

    // divider
    logic [DW-1:0]     r_q, r_rem, r_den;

    // result being built
    ssbn_pkg::t_status r_status;
    logic [ssbn_pkg::IDX_W-1:0] r_axis;
    logic [DW-1:0]     r_start_out;
    logic [OW-1:0]     r_end_out;
    logic [OW-1:0]     r_step_out;
    logic [DW-1:0]     r_len;

    // output register
    logic              r_out_valid;
    ssbn_pkg::t_status r_out_status;
    logic [ssbn_pkg::IDX_W-1:0] r_out_axis;
    logic [DW-1:0]     r_out_start;
    logic [OW-1:0]     r_out_end;
    logic [OW-1:0]     r_out_step;
    logic [DW-1:0]     r_out_len;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic st_idle, st_emit;
    logic in_accept, out_free, out_load;
    logic is_load;

    assign in_accept = i_in_valid && st_idle;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign out_load  = st_emit && out_free;
    assign is_load   = (i_req_type == ssbn_pkg::REQ_LOAD);

    // ------------------------------------------------------------------
    // axis checks at acceptance
    // ------------------------------------------------------------------
    logic [RKW-1:0] rank5, lim5, rank_eff;
    logic [RKW:0]   ax6;
    logic           ax_ok, ax_dup, step_zero, dim_in_range;
    logic [AW-1:0]  ax_idx;
    logic [MAX_RANK-1:0] seen_base;

    always_comb begin
        rank5    = {1'b0, r_rank};
        lim5     = RKW'(MAX_RANK);
        rank_eff = (rank5 > lim5) ? lim5 : rank5;
        // negative axis counts back from the rank
        ax6      = {{2{i_axis_raw[ssbn_pkg::AXIS_W-1]}}, i_axis_raw}
                 + (i_axis_raw[ssbn_pkg::AXIS_W-1] ? {1'b0, rank_eff} : '0);
        ax_ok    = !ax6[RKW] && (ax6[RKW-1:0] < rank_eff);
        ax_idx   = ax6[AW-1:0];
        seen_base = i_first_of_slice ? '0 : r_seen;
        ax_dup   = seen_base[ax_idx];
        n_seen   = seen_base;
        if (ax_ok && !ax_dup) begin
            n_seen[ax_idx] = 1'b1;
        end
        step_zero    = (i_step_raw == '0);
        dim_in_range = (int'(i_dim_index) < MAX_RANK);
    end

    // ------------------------------------------------------------------
    // serial pass: one bit of each raw field per cycle, lsb first
    // ------------------------------------------------------------------
    logic sc_msb;
    logic b_s, b_a, b_e, b_d, b_b, b_nb;
    logic add_a, add_e, b_x, b_y, c_x, c_y;

    always_comb begin
        sc_msb = (r_cnt == SCAN_LAST);
        b_s    = r_step_sr[0];
        b_a    = r_start_sr[0];
        b_e    = r_end_sr[0];
        b_d    = r_d_sr[0];
        b_b    = r_b_sr[0];
        b_nb   = b_b ^ r_nb_c;            // bit of -bound
        add_a  = r_start_neg & b_d;       // negative start gets the size added
        add_e  = r_end_neg & b_d;
        b_x    = b_a ^ add_a ^ r_sc;
        c_x    = (b_a & add_a) | (r_sc & (b_a ^ add_a));
        b_y    = b_e ^ add_e ^ r_ec;
        c_y    = (b_e & add_e) | (r_ec & (b_e ^ add_e));
    end

    // ------------------------------------------------------------------
    // assembly of clamped start, end and step
    // ------------------------------------------------------------------
    logic          dim_zero;
    logic [OW-1:0] bnd32, step_sel, d32, end_lo, end_sel;
    logic [DW-1:0] start_hi, start_sel;
    logic          end_low, end_sent;

    always_comb begin
        dim_zero  = (r_dim == '0);
        bnd32     = {1'b0, (dim_zero ? ssbn_pkg::S32_MAX : r_dim)};
        step_sel  = r_st_gt ? bnd32 : (r_st_lt ? (-bnd32) : r_step_sr[OW-1:0]);
        start_hi  = r_dim - DW'(r_step_neg);
        start_sel = r_start_sr[RW-1] ? '0 : (r_x_ge ? start_hi : r_start_sr[DW-1:0]);
        d32       = {1'b0, r_dim};
        end_lo    = r_step_neg ? '1 : '0;
        end_sent  = r_e32 || r_e64;
        // below -1 for a negative step, below 0 otherwise
        end_low   = r_end_sr[RW-1] && (!r_step_neg || !r_y_ones);
        if (end_sent) begin
            end_sel = r_step_neg ? '1 : d32;
        end else if (end_low) begin
            end_sel = end_lo;
        end else if (r_y_gt) begin
            end_sel = d32;
        end else begin
            end_sel = r_end_sr[OW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // numerator and divisor, both as magnitudes in the step's direction
    // ------------------------------------------------------------------
    logic [OW:0]   s33, e33, num33;
    logic [OW-1:0] den32;
    logic          num_pos;

    always_comb begin
        s33     = {2'b00, r_start_out};
        e33     = {r_end_out[OW-1], r_end_out};
        num33   = r_step_neg ? (s33 - e33) : (e33 - s33);
        num_pos = !num33[OW] && (num33 != '0);
        den32   = r_step_neg ? (-r_step_out) : r_step_out;
    end

    // restoring division step
    logic [OW-1:0] div_sh;
    logic [OW:0]   div_tr;
    logic          div_ok;

    always_comb begin
        div_sh = {r_rem, r_q[DW-1]};
        div_tr = {1'b0, div_sh} - {2'b00, r_den};
        div_ok = !div_tr[OW];
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ssbn_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (is_load || !ax_ok || ax_dup || step_zero) begin
                        n_state = ssbn_pkg::S_EMIT;
                    end else begin
                        n_state = ssbn_pkg::S_PREP;
                    end
                end
            end
            ssbn_pkg::S_PREP: n_state = ssbn_pkg::S_SCAN;
            ssbn_pkg::S_SCAN: begin
                if (sc_msb) begin
                    n_state = ssbn_pkg::S_ASM;
                end
            end
            ssbn_pkg::S_ASM: begin
                n_state = dim_zero ? ssbn_pkg::S_EMIT : ssbn_pkg::S_DIFF;
            end
            ssbn_pkg::S_DIFF: begin
                n_state = num_pos ? ssbn_pkg::S_DIV : ssbn_pkg::S_EMIT;
            end
            ssbn_pkg::S_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = ssbn_pkg::S_FIN;
                end
            end
            ssbn_pkg::S_FIN: n_state = ssbn_pkg::S_EMIT;
            ssbn_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = ssbn_pkg::S_IDLE;
                end
            end
            default: n_state = ssbn_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        st_idle = 1'b0;
        st_emit = 1'b0;
        case (r_state)
            ssbn_pkg::S_IDLE: st_idle = 1'b1;
            ssbn_pkg::S_EMIT: st_emit = 1'b1;
            default: begin
                st_idle = 1'b0;
                st_emit = 1'b0;
            end
        endcase
    end

    assign o_in_stall = !st_idle;

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssbn_pkg::S_IDLE;
            r_rank      <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_rank <= i_cfg_wdata;
            end
            if (in_accept && !is_load) begin
                r_seen <= n_seen;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // shape table: written by load items, read once per in-range axis item
    always_ff @(posedge i_clk) begin
        if (in_accept && is_load && dim_in_range) begin
            r_table[AW'(i_dim_index)] <= i_dim_size;
        end
        if (in_accept && !is_load && ax_ok) begin
            r_dim <= r_table[ax_idx];
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ssbn_pkg::S_IDLE: begin
                if (in_accept) begin
                    r_step_sr   <= i_step_raw;
                    r_start_sr  <= i_start_raw;
                    r_end_sr    <= i_end_raw;
                    r_step_neg  <= i_step_raw[RW-1];
                    r_start_neg <= i_start_raw[RW-1];
                    r_end_neg   <= i_end_raw[RW-1];
                    r_start_out <= '0;
                    r_end_out   <= '0;
                    r_step_out  <= '0;
                    r_len       <= '0;
                    if (is_load) begin
                        r_status <= ssbn_pkg::STAT_OK;
                        r_axis   <= '0;
                    end else if (!ax_ok) begin
                        r_status <= ssbn_pkg::STAT_RANGE;
                        r_axis   <= '0;
                    end else begin
                        r_axis <= ax6[ssbn_pkg::IDX_W-1:0];
                        if (ax_dup) begin
                            r_status <= ssbn_pkg::STAT_DUP;
                        end else if (step_zero) begin
                            r_status <= ssbn_pkg::STAT_ZSTEP;
                        end else begin
                            r_status <= ssbn_pkg::STAT_OK;
                        end
                    end
                end
            end
            ssbn_pkg::S_PREP: begin
                // a zero-size dimension saturates the step to the int32 range
                r_d_sr   <= r_dim;
                r_b_sr   <= dim_zero ? ssbn_pkg::S32_MAX : r_dim;
                r_st_gt  <= 1'b0;
                r_st_lt  <= 1'b0;
                r_nb_c   <= 1'b0;
                r_sc     <= 1'b0;
                r_ec     <= 1'b0;
                r_x_ge   <= r_step_neg;   // ties count as above for a negative step
                r_y_gt   <= 1'b0;
                r_y_ones <= 1'b1;
                r_e32    <= 1'b1;
                r_e64    <= 1'b1;
                r_cnt    <= '0;
            end
            ssbn_pkg::S_SCAN: begin
                r_step_sr  <= {b_s, r_step_sr[RW-1:1]};
                r_start_sr <= {b_x, r_start_sr[RW-1:1]};
                r_end_sr   <= {b_y, r_end_sr[RW-1:1]};
                r_d_sr     <= {1'b0, r_d_sr[DW-1:1]};
                r_b_sr     <= {1'b0, r_b_sr[DW-1:1]};
                r_nb_c     <= r_nb_c | b_b;
                r_sc       <= c_x;
                r_ec       <= c_y;
                // lsb-first compares: the highest differing bit decides,
                // and at the sign bit the operand holding a one is the smaller
                if (b_s ^ b_b) begin
                    r_st_gt <= sc_msb ? b_b : b_s;
                end
                if (b_nb ^ b_s) begin
                    r_st_lt <= sc_msb ? b_s : b_nb;
                end
                if (b_x ^ b_d) begin
                    r_x_ge <= sc_msb ? b_d : b_x;
                end
                if (b_y ^ b_d) begin
                    r_y_gt <= sc_msb ? b_d : b_y;
                end
                r_y_ones <= r_y_ones & b_y;
                r_e32    <= r_e32 & (b_e == (r_cnt < SENT_LOW));
                r_e64    <= r_e64 & (b_e == !sc_msb);
                r_cnt    <= r_cnt + 1'b1;
            end
            ssbn_pkg::S_ASM: begin
                r_step_out <= step_sel;
                if (!dim_zero) begin
                    r_start_out <= start_sel;
                    r_end_out   <= end_sel;
                end
            end
            ssbn_pkg::S_DIFF: begin
                r_q   <= num33[DW-1:0];
                r_den <= den32[DW-1:0];
                r_rem <= '0;
                r_cnt <= '0;
            end
            ssbn_pkg::S_DIV: begin
                r_rem <= div_ok ? div_tr[DW-1:0] : div_sh[DW-1:0];
                r_q   <= {r_q[DW-2:0], div_ok};
                r_cnt <= r_cnt + 1'b1;
            end
            ssbn_pkg::S_FIN: begin
                // ceiling: round up on a nonzero remainder
                r_len <= r_q + DW'(r_rem != '0);
            end
            ssbn_pkg::S_EMIT: begin
                if (out_free) begin
                    r_out_status <= r_status;
                    r_out_axis   <= r_axis;
                    r_out_start  <= r_start_out;
                    r_out_end    <= r_end_out;
                    r_out_step   <= r_step_out;
                    r_out_len    <= r_len;
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_axis_out   = r_out_axis;
    assign o_start_out  = r_out_start;
    assign o_end_out    = r_out_end;
    assign o_step_out   = r_out_step;
    assign o_out_length = r_out_len;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status != ssbn_pkg::STAT_OK) |->
            (r_out_start == '0) && (r_out_end == '0) && (r_out_step == '0)
            && (r_out_len == '0))
        else $error("rejected axis carries nonzero bounds");

    a_scan_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssbn_pkg::S_SCAN) && (r_cnt == SCAN_LAST) |=>
            (r_state == ssbn_pkg::S_ASM))
        else $error("serial pass did not end after the last bit");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssbn_pkg::S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssbn_pkg::S_DIFF) |->
            (r_start_out <= r_dim) && ($signed(r_end_out) <= $signed({1'b0, r_dim})))
        else $error("clamped start or end beyond dimension size");

endmodule

[tb/sv/slice_bounds_checker.sv]
// checker for the slice bounds normalizer: axis bounds predictor and in-order result compare
module slice_bounds_checker
    import ssbn_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [RANK_W-1:0]           i_cfg_wdata,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_req_type,
    input  logic [IDX_W-1:0]            i_dim_index,
    input  logic [DIM_W-1:0]            i_dim_size,
    input  logic                        i_first_of_slice,
    input  logic signed [AXIS_W-1:0]    i_axis_raw,
    input  logic signed [RAW_W-1:0]     i_start_raw,
    input  logic signed [RAW_W-1:0]     i_end_raw,
    input  logic signed [RAW_W-1:0]     i_step_raw,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [1:0]                  i_status,
    input  logic [IDX_W-1:0]            i_axis_out,
    input  logic [DIM_W-1:0]            i_start_out,
    input  logic signed [OUT_W-1:0]     i_end_out,
    input  logic signed [OUT_W-1:0]     i_step_out,
    input  logic [DIM_W-1:0]            i_out_length,
    output int                          o_fail_count,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint END_TO_LAST32 = 64'sd2147483647;
    localparam longint END_TO_LAST64 = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint STEP_LIMIT    = 64'sd2147483647;

    typedef struct packed {
        t_status                 status;
        logic [IDX_W-1:0]        axis;
        logic [DIM_W-1:0]        start_idx;
        logic signed [OUT_W-1:0] end_idx;
        logic signed [OUT_W-1:0] step_val;
        logic [DIM_W-1:0]        length;
    } t_bounds;

    logic [DIM_W-1:0]  dim_table [MAX_RANK_DEF];
    logic [7:0]        seen_mask = '0;
    logic [RANK_W-1:0] cfg_rank = '0;
    t_bounds           bounds_q[$];
    int                fail_count = 0;
    int                pending = 0;
    int                results_seen = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    task automatic report_mismatch(input string what, input logic signed [63:0] got_v,
                                   input logic signed [63:0] want_v);
        if (fail_count < 100)
            $display("mismatch at result %0d, %s: got %0d want %0d",
                     results_seen, what, got_v, want_v);
        fail_count++;
    endtask

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // expected bounds for one item; updates the shape table and the seen mask
    function automatic t_bounds normalize_item(input logic req, input logic [IDX_W-1:0] idx,
                                               input logic [DIM_W-1:0] size, input logic first,
                                               input logic signed [AXIS_W-1:0] ax_raw,
                                               input longint start_raw, input longint end_raw,
                                               input longint step_raw);
        t_bounds r;
        longint  rank, ax, d, stp, st, en, diff, q, rem;
        r = '0;
        if (t_req'(req) == REQ_LOAD) begin
            dim_table[idx] = size;
            return r;
        end
        if (first)
            seen_mask = '0;
        rank = (cfg_rank > MAX_RANK_DEF) ? MAX_RANK_DEF : cfg_rank;
        ax = ax_raw;
        if (ax < 0)
            ax += rank;
        if (ax < 0 || ax >= rank) begin
            r.status = STAT_RANGE;
            return r;
        end
        r.axis = ax[IDX_W-1:0];
        if (seen_mask[ax[2:0]]) begin
            r.status = STAT_DUP;
            return r;
        end
        seen_mask[ax[2:0]] = 1'b1;
        if (step_raw == 0) begin
            r.status = STAT_ZSTEP;
            return r;
        end
        d = dim_table[ax[2:0]];
        // empty dimension: only the saturated step survives
        if (d == 0) begin
            stp = clamp_to(step_raw, -STEP_LIMIT, STEP_LIMIT);
            r.step_val = stp[OUT_W-1:0];
            return r;
        end
        stp = clamp_to(step_raw, -d, d);
        st = start_raw;
        if (st < 0)
            st += d;
        st = clamp_to(st, 0, (stp < 0) ? d - 1 : d);
        if (end_raw == END_TO_LAST32 || end_raw == END_TO_LAST64) begin
            en = (stp < 0) ? -1 : d;
        end else begin
            en = end_raw;
            if (en < 0)
                en += d;
            en = clamp_to(en, (stp < 0) ? -1 : 0, d);
        end
        // ceiling division, rounding away from zero only in the step's direction
        diff = en - st;
        q = diff / stp;
        rem = diff % stp;
        if (rem != 0 && ((rem > 0) == (stp > 0)))
            q++;
        if (q < 0)
            q = 0;
        r.start_idx = st[DIM_W-1:0];
        r.end_idx   = en[OUT_W-1:0];
        r.step_val  = stp[OUT_W-1:0];
        r.length    = q[DIM_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_bounds got, want, expected;
        if (!i_rst_n) begin
            seen_mask = '0;
            cfg_rank = '0;
            bounds_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_status, i_axis_out, i_start_out, i_end_out, i_step_out, i_out_length};
                if (bounds_q.size() == 0) begin
                    report_mismatch("result with nothing expected, status", got.status, 0);
                end else begin
                    want = bounds_q.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.axis !== want.axis)
                        report_mismatch("axis_out", got.axis, want.axis);
                    if (got.start_idx !== want.start_idx)
                        report_mismatch("start_out", got.start_idx, want.start_idx);
                    if (got.end_idx !== want.end_idx)
                        report_mismatch("end_out", got.end_idx, want.end_idx);
                    if (got.step_val !== want.step_val)
                        report_mismatch("step_out", got.step_val, want.step_val);
                    if (got.length !== want.length)
                        report_mismatch("out_length", got.length, want.length);
                end
                results_seen++;
            end
            if (i_cfg_we)
                cfg_rank = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                expected = normalize_item(i_req_type, i_dim_index, i_dim_size,
                                          i_first_of_slice, i_axis_raw, i_start_raw,
                                          i_end_raw, i_step_raw);
                bounds_q.insert(bounds_q.size(), expected);
            end
        end
        pending <= bounds_q.size();
    end

endmodule

[tb/sv/tb.sv]
// top of the slice bounds normalizer testbench: clock, reset, stimulus and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssbn_pkg::*;

    localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint END32   = 64'sd2147483647;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [RANK_W-1:0]        cfg_wdata = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     req_type = 1'b0;
    logic [IDX_W-1:0]         dim_index = '0;
    logic [DIM_W-1:0]         dim_size = '0;
    logic                     first_of_slice = 1'b0;
    logic signed [AXIS_W-1:0] axis_raw = '0;
    logic signed [RAW_W-1:0]  start_raw = '0;
    logic signed [RAW_W-1:0]  end_raw = '0;
    logic signed [RAW_W-1:0]  step_raw = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [1:0]               status;
    logic [IDX_W-1:0]         axis_out;
    logic [DIM_W-1:0]         start_out;
    logic signed [OUT_W-1:0]  end_out;
    logic signed [OUT_W-1:0]  step_out;
    logic [DIM_W-1:0]         out_length;

    int mismatches;
    int outstanding;

    // idling percentages of the current phase
    int idle_pct = 0;
    int stall_pct = 0;

    // what the stimulus knows about the block, used only to aim the random values
    int     rank_now = 0;
    longint dims_now [MAX_RANK_DEF];

    strided_slice_bounds_normalizer uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_req_type       (req_type),
        .i_dim_index      (dim_index),
        .i_dim_size       (dim_size),
        .i_first_of_slice (first_of_slice),
        .i_axis_raw       (axis_raw),
        .i_start_raw      (start_raw),
        .i_end_raw        (end_raw),
        .i_step_raw       (step_raw),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_status         (status),
        .o_axis_out       (axis_out),
        .o_start_out      (start_out),
        .o_end_out        (end_out),
        .o_step_out       (step_out),
        .o_out_length     (out_length)
    );

    slice_bounds_checker bounds_chk (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_req_type       (req_type),
        .i_dim_index      (dim_index),
        .i_dim_size       (dim_size),
        .i_first_of_slice (first_of_slice),
        .i_axis_raw       (axis_raw),
        .i_start_raw      (start_raw),
        .i_end_raw        (end_raw),
        .i_step_raw       (step_raw),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_status         (status),
        .i_axis_out       (axis_out),
        .i_start_out      (start_out),
        .i_end_out        (end_out),
        .i_step_out       (step_out),
        .i_out_length     (out_length),
        .o_fail_count     (mismatches),
        .o_pending        (outstanding)
    );

    // 8 ns clock
    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // receiver stalls at random, one decision per cycle
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // one item: optional idle cycles, then hold it until the block takes it
    // valid stays high on return so back-to-back items never drop it
    task automatic send_item(input t_req kind, input int idx, input longint size,
                             input logic first, input logic signed [AXIS_W-1:0] ax,
                             input longint st, input longint en, input longint stp);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        req_type       <= kind;
        dim_index      <= idx[IDX_W-1:0];
        dim_size       <= size[DIM_W-1:0];
        first_of_slice <= first;
        axis_raw       <= ax;
        start_raw      <= st;
        end_raw        <= en;
        step_raw       <= stp;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // load item, the axis fields carry noise
    task automatic load_dim(input int idx, input longint size);
        dims_now[idx] = size;
        send_item(REQ_LOAD, idx, size, 1'($urandom), 4'($urandom), {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    // axis item, the load fields carry noise
    task automatic axis_item(input logic first, input logic signed [AXIS_W-1:0] ax,
                             input longint st, input longint en, input longint stp);
        send_item(REQ_AXIS, $urandom_range(7), longint'($urandom), first, ax, st, en, stp);
    endtask

    // sender holds off until every expected result is back
    // the first edge lets the checker's count catch up with the last acceptance
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // rank is only changed while the block is idle
    task automatic set_rank(input int r);
        wait_drained();
        rank_now = r;
        cfg_we    <= 1'b1;
        cfg_wdata <= r[RANK_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly small sizes, some empty, some up to the full 31 bits
    function automatic longint pick_dim();
        case ($urandom_range(9))
            0:             return 0;
            1, 2, 3, 4, 5: return $urandom_range(12, 1);
            6, 7:          return $urandom_range(5000, 13);
            8:             return 64'sd2147483647;
            default:       return longint'($urandom >> 1);
        endcase
    endfunction

    // start or end value: around the dimension, the end sentinels, the extremes
    function automatic longint pick_bound(input longint d);
        int sp;
        sp = (d > 1000) ? 1000 : int'(d);
        case ($urandom_range(11))
            0, 1, 2, 3: return longint'($urandom_range(2 * sp + 6)) - sp - 3;
            4:          return d + longint'($urandom_range(4)) - 2;
            5:          return -d + longint'($urandom_range(4)) - 2;
            6:          return END32;
            7:          return I64_MAX;
            8:          return $urandom_range(1) ? I64_MIN : I64_MAX - 1;
            9:          return ($urandom_range(1) ? END32 : -END32) + longint'($urandom_range(2)) - 1;
            default:    return {$urandom, $urandom};
        endcase
    endfunction

    // step value: small of either sign, zero, the dimension itself, the extremes
    function automatic longint pick_step(input longint d);
        int     sp;
        longint mag;
        sp = (d > 10) ? 10 : int'(d);
        case ($urandom_range(11))
            0, 1, 2, 3, 4, 5: mag = longint'($urandom_range(sp + 2, 1));
            6:                mag = 0;
            7:                mag = d + longint'($urandom_range(2));
            8:                return $urandom_range(1) ? I64_MIN : I64_MAX;
            9:                mag = END32 + longint'($urandom_range(2));
            default:          return {$urandom, $urandom};
        endcase
        return $urandom_range(1) ? -mag : mag;
    endfunction

    // random slices: mostly fresh axes within the rank, some repeats, some noise,
    // with dimension reloads sprinkled in
    task automatic run_segment(input int n_items);
        int                       sent, slice_left, eff, a, wr;
        logic [7:0]               used, full;
        logic                     first;
        logic signed [AXIS_W-1:0] ax;
        int                       pick;
        longint                   d;
        sent = 0;
        slice_left = 0;
        used = '0;
        eff = (rank_now > MAX_RANK_DEF) ? MAX_RANK_DEF : rank_now;
        full = 8'((9'd1 << eff) - 1);
        while (sent < n_items) begin
            if ($urandom_range(99) < 8) begin
                a = $urandom_range(7);
                load_dim(a, pick_dim());
            end else begin
                first = 1'b0;
                if (slice_left == 0) begin
                    slice_left = $urandom_range(9, 1);
                    // now and then a new slice forgets to clear the seen mask
                    if ($urandom_range(9) != 0) begin
                        first = 1'b1;
                        used = '0;
                    end
                end
                pick = $urandom_range(99);
                if (pick < 75 && used != full) begin
                    do
                        a = $urandom_range(eff - 1);
                    while (used[a]);
                    ax = $urandom_range(1) ? AXIS_W'(a - eff) : AXIS_W'(a);
                end else if (pick < 87 && used != 0) begin
                    do
                        a = $urandom_range(eff - 1);
                    while (!used[a]);
                    ax = $urandom_range(1) ? AXIS_W'(a - eff) : AXIS_W'(a);
                end else begin
                    ax = AXIS_W'($urandom_range(15));
                end
                wr = ax;
                if (wr < 0)
                    wr += eff;
                d = 10;
                if (wr >= 0 && wr < eff) begin
                    used[wr] = 1'b1;
                    d = dims_now[wr];
                end
                axis_item(first, ax, pick_bound(d), pick_bound(d), pick_step(d));
                slice_left--;
            end
            sent++;
            if ($urandom_range(149) == 0)
                wait_drained();
        end
    endtask

    initial begin
        int seg_rank [8];
        seg_rank = '{8, 15, 3, 0, 8, 1, 5, 8};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rank is zero out of reset: every axis is out of range
        axis_item(1'b1, 4'sd0, 0, 5, 1);

        // fill the whole shape table before any axis can read it
        load_dim(0, 10);
        load_dim(1, 0);
        load_dim(2, 64'sd2147483647);
        load_dim(3, 1);
        load_dim(4, 7);
        load_dim(5, 5);
        load_dim(6, 3);
        load_dim(7, 100);

        set_rank(8);
        axis_item(1'b1, 4'sd0, 2, 8, 2);               // plain forward slice
        axis_item(1'b0, -4'sd8, 0, 10, 1);             // same axis counted from the back
        axis_item(1'b0, 4'sd1, 5, 9, I64_MIN);         // empty dimension, step saturates
        axis_item(1'b0, 4'sd2, I64_MIN, I64_MAX, I64_MAX); // widest dimension, to the end
        axis_item(1'b0, 4'sd3, 0, 1, 0);               // zero step still marks the axis
        axis_item(1'b0, 4'sd3, 0, 1, 1);               // so this one is a repeat
        axis_item(1'b0, -4'sd4, -1, END32, -1);        // reverse walk down to index -1
        axis_item(1'b0, 4'sd5, 10, -100, -2);          // start and end both clamp
        axis_item(1'b0, 4'sd6, 0, 3, 5);               // step clamps to the dimension
        axis_item(1'b0, 4'sd7, -150, END32 + 1, 3);    // just past the sentinel is a number
        axis_item(1'b1, -4'sd1, 99, 0, -1);            // new slice may reuse an axis
        axis_item(1'b0, 4'sd7, 0, 0, 1);               // repeat within that slice

        set_rank(15);
        axis_item(1'b1, -4'sd8, 3, 3, 1);              // rank saturates, empty range
        axis_item(1'b0, 4'sd7, 0, I64_MIN, 1);         // end far below zero

        set_rank(3);
        axis_item(1'b1, 4'sd3, 0, 1, 1);               // one past the rank
        axis_item(1'b0, -4'sd4, 0, 1, 1);              // one before the first axis
        axis_item(1'b0, -4'sd3, 0, 10, 3);             // wraps to axis 0

        // random part: idling off, sender idle, receiver stalling, both
        for (int seg = 0; seg < 8; seg++) begin
            set_rank(seg_rank[seg]);
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            run_segment(200);
        end

        wait_drained();
        repeat (120) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("strided_slice_bounds_normalizer regression: pass");
        else
            $display("strided_slice_bounds_normalizer regression: fail");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("strided_slice_bounds_normalizer regression: fail");
        $finish;
    end

endmodule
